// File: src/swkm_pkg.sv
// Shared types, constants and default keyword table of the sliding window keyword matcher.
package swkm_pkg;

    localparam int MAX_KEY_LEN_DEF = 20;
    localparam int NUM_ENTRIES_DEF = 32;

    localparam logic [1:0] CMD_KEY  = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_LEN  = 2'd2;

    // default table: words are right-justified, first character in the top used byte
    localparam int DEF_COUNT  = 19;
    localparam int DEF_WORD_W = 7;

    localparam logic [DEF_WORD_W*8-1:0] DEF_WORDS [DEF_COUNT] = '{
        "NRG", "OTWO", "MAP", "BYE", "NUKE", "SEE", "WOW", "MAG", "RIF", "POW",
        "TOAST", "MELT", "PUFF", "ZIP", "PZBXAY", "AMMO", "QWE", "SHIT", "YOURMOM"
    };
    localparam int DEF_LENS [DEF_COUNT] = '{
        3, 4, 3, 3, 4, 3, 3, 3, 3, 3, 5, 4, 4, 3, 6, 4, 3, 4, 7
    };
    localparam logic [4:0] DEF_TAGS [DEF_COUNT] = '{
        5'd0, 5'd1, 5'd2, 5'd5, 5'd4, 5'd7, 5'd6, 5'd8, 5'd9, 5'd10,
        5'd11, 5'd3, 5'd13, 5'd14, 5'd12, 5'd15, 5'd18, 5'd19, 5'd20
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RES
    } swkm_state_t;

    typedef struct packed {
        logic       char_en;
        logic       len_en;
        logic [4:0] index;
        logic [4:0] position;
        logic [7:0] value;
        logic [4:0] length;
    } swkm_wr_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } swkm_win_ctrl_t;

    function automatic logic [7:0] fold_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7a)
        begin
            r = b - 8'h20;
        end
        return r;
    endfunction

    function automatic logic [7:0] def_char(input int e, input int k);
        logic [7:0] c;
        c = 8'h00;
        if (e < DEF_COUNT)
        begin
            if (k < DEF_LENS[e])
            begin
                c = DEF_WORDS[e][(DEF_LENS[e]-1-k)*8 +: 8];
            end
        end
        return c;
    endfunction

    function automatic int def_len(input int e, input int max_len);
        int n;
        n = 0;
        if (e < DEF_COUNT)
        begin
            n = (DEF_LENS[e] > max_len) ? max_len : DEF_LENS[e];
        end
        return n;
    endfunction

    function automatic logic [4:0] def_tag(input int e);
        logic [4:0] t;
        t = 5'd0;
        if (e < DEF_COUNT)
        begin
            t = DEF_TAGS[e];
        end
        return t;
    endfunction

endpackage

// File: src/sliding_window_keyword_matcher.sv
// Top level of the sliding window keyword matcher: window row, entry row and sequencer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------------
//   in      | input     | in_valid / in_ready  | cmd, key_char, entry_index, char_position,
//           |           |                      | char_value, entry_length
//   out     | output    | out_valid/out_ready  | matched, match_tag
//
// Steps per beat: the accept edge shifts the window or writes the table, the next edge
// registers every entry cell's suffix compare, and the resolve step, once the output is
// free, moves the first hit by index into the output register.
// A stalled output holds the sequencer in its resolve step; one finished beat may wait
// in the output register while that happens.
// Reset: the window clears to zeros and every entry cell loads its default keyword and
// length at once, tags being fixed constants; no sweep follows, the first beat can be
// taken straight away.
//
// The window is a row of byte cells that pass the new character towards the oldest
// position; each table entry is a cell of its own comparing the window suffix with its
// keyword for every possible length and picking the compare for its stored length.
module sliding_window_keyword_matcher #(
    parameter int MAX_KEY_LEN = swkm_pkg::MAX_KEY_LEN_DEF,
    parameter int NUM_ENTRIES = swkm_pkg::NUM_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] key_char,
    input  logic [4:0] entry_index,
    input  logic [4:0] char_position,
    input  logic [7:0] char_value,
    input  logic [4:0] entry_length,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic [4:0] match_tag
);
    import swkm_pkg::*;

    swkm_state_t state_reg;
    swkm_state_t state_next;

    logic       key_reg;
    logic       key_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       matched_reg;
    logic       matched_next;
    logic [4:0] tag_reg;
    logic [4:0] tag_next;

    logic       accept;
    logic       out_free;
    logic       res_done;
    logic       found;
    logic [4:0] tag_sel;
    logic [7:0] key_fold;

    swkm_wr_t       wr;
    swkm_win_ctrl_t win_ctrl;

    logic [MAX_KEY_LEN-1:0][7:0] win;
    logic [NUM_ENTRIES-1:0]      hit_vec;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign res_done = (state_reg == ST_RES) && out_free;
    assign key_fold = fold_upper(key_char);

    // table writes land on the accept edge
    always_comb
    begin
        wr.char_en  = accept && (cmd == CMD_LOAD);
        wr.len_en   = accept && (cmd == CMD_LEN);
        wr.index    = entry_index;
        wr.position = char_position;
        wr.value    = fold_upper(char_value);
        wr.length   = entry_length;
    end

    // shift on a key beat, drop the whole window once its hit is reported
    always_comb
    begin
        win_ctrl.shift = accept && (cmd == CMD_KEY);
        win_ctrl.clear = res_done && found && key_reg;
    end

    // window row: the newest byte enters at the top position
    for (genvar j = 0; j < MAX_KEY_LEN; j++)
    begin : g_win
        logic [7:0] shift_in;
        if (j == MAX_KEY_LEN - 1)
        begin : g_head
            assign shift_in = key_fold;
        end
        else
        begin : g_body
            assign shift_in = win[j+1];
        end
        swkm_win_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (win_ctrl),
            .shift_in (shift_in),
            .byte_out (win[j])
        );
    end

    // entry row
    for (genvar e = 0; e < NUM_ENTRIES; e++)
    begin : g_entry
        swkm_entry_cell #(
            .MAX_KEY_LEN (MAX_KEY_LEN),
            .ENTRY       (e)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .wr    (wr),
            .win   (win),
            .hit   (hit_vec[e])
        );
    end

    // lowest index wins: scan downwards so the earliest hit is written last
    always_comb
    begin
        found   = 1'b0;
        tag_sel = 5'd0;
        for (int e = NUM_ENTRIES - 1; e >= 0; e--)
        begin
            if (hit_vec[e] && key_reg)
            begin
                found   = 1'b1;
                tag_sel = def_tag(e);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;
        tag_next       = tag_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next   = (cmd == CMD_KEY);
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    matched_next   = found;
                    tag_next       = tag_sel;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        tag_reg     <= tag_next;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign match_tag = tag_reg;

    // a fresh result only ever comes out of the resolve step
    a_rise_from_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RES))
        else $error("result raised outside the resolve step");

    // a miss carries a zero tag
    a_miss_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !matched_reg) |-> (tag_reg == 5'd0))
        else $error("miss reported with a nonzero tag");

    // a reported hit leaves an empty window behind
    a_clear_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (res_done && found) |=> (win == '0))
        else $error("window not cleared after a hit");

    // table and length beats never report a match
    a_nonkey_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (res_done && !key_reg) |=> (out_valid_reg && !matched_reg))
        else $error("non-key beat reported a match");

endmodule

// File: src/swkm_win_cell.sv
// One byte of the history window: shifts from its neighbour, clears on a hit.
module swkm_win_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  swkm_pkg::swkm_win_ctrl_t ctrl,
    input  logic [7:0]              shift_in,
    output logic [7:0]              byte_out
);
    import swkm_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = 8'h00;
        end
        else if (ctrl.shift)
        begin
            byte_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

// File: src/swkm_entry_cell.sv
// One keyword table entry: stores its bytes and length, registers its suffix match.
module swkm_entry_cell #(
    parameter int MAX_KEY_LEN = swkm_pkg::MAX_KEY_LEN_DEF,
    parameter int ENTRY       = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  swkm_pkg::swkm_wr_t                wr,
    input  logic [MAX_KEY_LEN-1:0][7:0]       win,
    output logic                              hit
);
    import swkm_pkg::*;

    localparam int LEN_W = $clog2(MAX_KEY_LEN + 1);

    logic [7:0]       kw_reg [MAX_KEY_LEN];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             hit_reg;
    logic [MAX_KEY_LEN:0] match_vec;
    logic             sel_entry;

    assign sel_entry = (32'(wr.index) == ENTRY);

    // match_vec[n]: the last n window bytes equal the first n keyword bytes
    always_comb
    begin
        logic [MAX_KEY_LEN-1:0] eqn;
        match_vec = '0;
        for (int n = 1; n <= MAX_KEY_LEN; n++)
        begin
            eqn = '1;
            for (int k = 0; k < n; k++)
            begin
                eqn[k] = (kw_reg[k] == win[MAX_KEY_LEN-n+k]);
            end
            match_vec[n] = &eqn;
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (wr.len_en && sel_entry)
        begin
            if (32'(wr.length) > MAX_KEY_LEN)
            begin
                len_next = LEN_W'(MAX_KEY_LEN);
            end
            else
            begin
                len_next = LEN_W'(wr.length);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_KEY_LEN; k++)
            begin
                kw_reg[k] <= def_char(ENTRY, k);
            end
            len_reg <= LEN_W'(def_len(ENTRY, MAX_KEY_LEN));
            hit_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < MAX_KEY_LEN; k++)
            begin
                if (wr.char_en && sel_entry && 32'(wr.position) == k)
                begin
                    kw_reg[k] <= wr.value;
                end
            end
            len_reg <= len_next;
            hit_reg <= match_vec[len_reg];
        end
    end

    assign hit = hit_reg;

endmodule

// File: dv/tb_sliding_window_keyword_matcher.sv
// Self-checking testbench for the sliding window keyword matcher.
module tb_sliding_window_keyword_matcher;

    timeunit 1ns;
    timeprecision 1ps;

    import swkm_pkg::*;

    localparam int MAX_LEN     = MAX_KEY_LEN_DEF;
    localparam int ENTRIES     = NUM_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BEATS = 340;

    // The package names three selector codes; the fourth neither shifts nor writes and is answered with a miss.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Shadow of the keyword table and the history window. Each accepted beat is
    // folded in here in acceptance order and leaves one predicted verdict behind.
    class keyword_scoreboard;

        typedef struct {
            logic       matched;
            logic [4:0] tag;
        } verdict_t;

        logic [7:0] window [MAX_LEN];
        logic [7:0] kw_bytes [ENTRIES][MAX_LEN];
        logic [4:0] kw_len [ENTRIES];
        logic [4:0] kw_tag [ENTRIES];
        verdict_t   awaited [$];
        int         errors;
        int         n_key;
        int         n_load;
        int         n_len;
        int         n_spare;
        int         n_hits;

        function new();
            errors  = 0;
            n_key   = 0;
            n_load  = 0;
            n_len   = 0;
            n_spare = 0;
            n_hits  = 0;
            load_stock_table();
        endfunction

        // Fold a-z to A-Z, leave every other byte alone.
        function logic [7:0] upcase(input logic [7:0] b);
            logic [7:0] r;
            r = b;
            if (b >= 8'h61 && b <= 8'h7a)
            begin
                r = b - 8'h20;
            end
            return r;
        endfunction

        function void load_stock_table();
            string       words [19];
            logic [4:0]  tags [19];
            words = '{"NRG", "OTWO", "MAP", "BYE", "NUKE", "SEE", "WOW", "MAG", "RIF",
                      "POW", "TOAST", "MELT", "PUFF", "ZIP", "PZBXAY", "AMMO", "QWE",
                      "SHIT", "YOURMOM"};
            tags  = '{5'd0, 5'd1, 5'd2, 5'd5, 5'd4, 5'd7, 5'd6, 5'd8, 5'd9, 5'd10,
                      5'd11, 5'd3, 5'd13, 5'd14, 5'd12, 5'd15, 5'd18, 5'd19, 5'd20};
            foreach (window[i])
            begin
                window[i] = 8'h00;
            end
            foreach (kw_bytes[e, k])
            begin
                kw_bytes[e][k] = 8'h00;
            end
            foreach (kw_len[e])
            begin
                kw_len[e] = 5'd0;
                kw_tag[e] = 5'd0;
            end
            for (int e = 0; e < 19 && e < ENTRIES; e++)
            begin
                for (int k = 0; k < words[e].len() && k < MAX_LEN; k++)
                begin
                    kw_bytes[e][k] = words[e][k];
                end
                kw_len[e] = 5'(words[e].len());
                kw_tag[e] = tags[e];
            end
        endfunction

        function void note_input(input logic [1:0] c, input logic [7:0] key_char,
                                 input logic [4:0] idx, input logic [4:0] pos,
                                 input logic [7:0] value, input logic [4:0] length);
            verdict_t v;
            int       n;
            bit       hit;
            v.matched = 1'b0;
            v.tag     = 5'd0;
            case (c)
                CMD_KEY:
                begin
                    n_key++;
                    for (int i = 0; i + 1 < MAX_LEN; i++)
                    begin
                        window[i] = window[i + 1];
                    end
                    window[MAX_LEN - 1] = upcase(key_char);
                    for (int e = 0; e < ENTRIES && !v.matched; e++)
                    begin
                        n = kw_len[e];
                        if (n == 0 || n > MAX_LEN)
                        begin
                            continue;
                        end
                        hit = 1'b1;
                        for (int k = 0; k < n; k++)
                        begin
                            if (kw_bytes[e][k] != window[MAX_LEN - n + k])
                            begin
                                hit = 1'b0;
                            end
                        end
                        if (hit)
                        begin
                            v.matched = 1'b1;
                            v.tag     = kw_tag[e];
                        end
                    end
                    if (v.matched)
                    begin
                        n_hits++;
                        foreach (window[i])
                        begin
                            window[i] = 8'h00;
                        end
                    end
                end
                CMD_LOAD:
                begin
                    n_load++;
                    if (idx < ENTRIES && pos < MAX_LEN)
                    begin
                        kw_bytes[idx][pos] = upcase(value);
                    end
                end
                CMD_LEN:
                begin
                    n_len++;
                    if (idx < ENTRIES)
                    begin
                        kw_len[idx] = (length > MAX_LEN) ? 5'(MAX_LEN) : length;
                    end
                end
                default:
                begin
                    n_spare++;
                end
            endcase
            awaited.push_back(v);
        endfunction

        function void check_result(input logic matched, input logic [4:0] tag);
            verdict_t v;
            if (awaited.size() == 0)
            begin
                $error("result with nothing awaited: matched %0b match_tag %0d", matched, tag);
                errors++;
                return;
            end
            v = awaited.pop_front();
            if (matched !== v.matched)
            begin
                $error("matched: expected %0b, got %0b", v.matched, matched);
                errors++;
            end
            if (tag !== v.tag)
            begin
                $error("match_tag: expected %0d, got %0d", v.tag, tag);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] cmd = CMD_KEY;
    logic [7:0] key_char = 8'h00;
    logic [4:0] entry_index = 5'd0;
    logic [4:0] char_position = 5'd0;
    logic [7:0] char_value = 8'h00;
    logic [4:0] entry_length = 5'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       matched;
    logic [4:0] match_tag;

    // idle chances in percent, set per phase by the stimulus
    int unsigned tx_idle_pct = 9;
    int unsigned rx_idle_pct = 73;
    // bumped by the stimulus each time it wants the receiver to hold off
    int unsigned hold_requests = 0;
    int unsigned cycle_count = 0;

    keyword_scoreboard sb = new();

    sliding_window_keyword_matcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .key_char      (key_char),
        .entry_index   (entry_index),
        .char_position (char_position),
        .char_value    (char_value),
        .entry_length  (entry_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .matched       (matched),
        .match_tag     (match_tag)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one beat: idle at random first, then hold valid and the payload
    // steady until the handshake edge, and note the beat in the shadow model.
    task automatic drive_beat(input logic [1:0] c, input logic [7:0] kc,
                              input logic [4:0] idx, input logic [4:0] pos,
                              input logic [7:0] val, input logic [4:0] len);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= c;
        key_char      <= kc;
        entry_index   <= idx;
        char_position <= pos;
        char_value    <= val;
        entry_length  <= len;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_input(c, kc, idx, pos, val, len);
    endtask

    // Key beat; the fields that the block ignores for it carry junk.
    task automatic send_key(input logic [7:0] ch);
        drive_beat(CMD_KEY, ch, 5'($urandom), 5'($urandom), 8'($urandom), 5'($urandom));
    endtask

    // Random traffic. Most of it is key beats that spell out whatever the table
    // holds right now, so hits keep coming as entries get rewritten; the rest is
    // table writes, free text, odd bytes and the spare selector.
    task automatic run_random(input int beats);
        int          sent;
        int unsigned r;
        int          e;
        int          tries;
        logic [7:0]  ch;
        logic [4:0]  idx;
        sent = 0;
        while (sent < beats)
        begin
            r = $urandom_range(99);
            // table writes lean towards the spare entries so the stock words survive
            idx = ($urandom_range(99) < 70) ? 5'($urandom_range(ENTRIES - 1, 19))
                                            : 5'($urandom_range(ENTRIES - 1));
            if (r < 8)
            begin
                ch = ($urandom_range(99) < 80) ? 8'h41 + 8'($urandom_range(25))
                                               : 8'($urandom);
                if ($urandom_range(1) == 1 && ch >= 8'h41 && ch <= 8'h5a)
                begin
                    ch = ch + 8'h20;
                end
                drive_beat(CMD_LOAD, 8'($urandom), idx,
                           ($urandom_range(99) < 90) ? 5'($urandom_range(MAX_LEN - 1))
                                                     : 5'($urandom_range(31)),
                           ch, 5'($urandom));
                sent++;
            end
            else if (r < 13)
            begin
                drive_beat(CMD_LEN, 8'($urandom), idx, 5'($urandom), 8'($urandom),
                           ($urandom_range(99) < 85) ? 5'($urandom_range(8, 1))
                                                     : 5'($urandom_range(31)));
                sent++;
            end
            else if (r < 15)
            begin
                // spare selector: leaves window and table alone, so it is not counted towards the beats sent
                drive_beat(CMD_SPARE, 8'($urandom), 5'($urandom), 5'($urandom),
                           8'($urandom), 5'($urandom));
            end
            else if (r < 65)
            begin
                e = $urandom_range(ENTRIES - 1);
                tries = 0;
                while (sb.kw_len[e] == 0 && tries < 8)
                begin
                    e = $urandom_range(ENTRIES - 1);
                    tries++;
                end
                if (sb.kw_len[e] == 0)
                begin
                    send_key(8'h41 + 8'($urandom_range(25)));
                    sent++;
                end
                else
                begin
                    for (int k = 0; k < sb.kw_len[e]; k++)
                    begin
                        ch = sb.kw_bytes[e][k];
                        if ($urandom_range(1) == 1 && ch >= 8'h41 && ch <= 8'h5a)
                        begin
                            ch = ch + 8'h20;
                        end
                        send_key(ch);
                        sent++;
                    end
                end
            end
            else
            begin
                ch = ($urandom_range(99) < 85) ? 8'h41 + 8'($urandom_range(25))
                                               : 8'($urandom);
                if ($urandom_range(1) == 1 && ch >= 8'h41 && ch <= 8'h5a)
                begin
                    ch = ch + 8'h20;
                end
                send_key(ch);
                sent++;
            end
        end
    endtask

    // Receiver: stall at random, or hold off completely for a long stretch
    // whenever the stimulus asks, counting the stretch down here.
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Check each result beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(matched, match_tag);
        end
    end

    // Watchdog: give up well past the slowest legal run.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sliding_window_keyword_matcher: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening, sender lightly idle and receiver heavily stalled.
        // Lower-case stock word folds to upper case and hits.
        send_key(8'h6e);
        send_key(8'h72);
        send_key(8'h67);
        // extremes of the key byte
        send_key(8'hff);
        send_key(8'h00);
        // build a two-letter word in a spare entry from mixed-case bytes, then type it
        drive_beat(CMD_LOAD, 8'h00, 5'd20, 5'd0, 8'h71, 5'd0);
        drive_beat(CMD_LOAD, 8'h00, 5'd20, 5'd1, 8'h5a, 5'd0);
        drive_beat(CMD_LEN, 8'h00, 5'd20, 5'd0, 8'h00, 5'd2);
        send_key(8'h71);
        send_key(8'h7a);
        // position past the keyword end is dropped; a length above the maximum
        // saturates, so nineteen zero bytes then 0xff hit the top entry
        drive_beat(CMD_LOAD, 8'hff, 5'd31, 5'd19, 8'hff, 5'd31);
        drive_beat(CMD_LOAD, 8'hff, 5'd31, 5'd31, 8'h61, 5'd31);
        drive_beat(CMD_LEN, 8'hff, 5'd31, 5'd31, 8'hff, 5'd31);
        send_key(8'hff);
        // zero keyword bytes match zero window bytes
        drive_beat(CMD_LEN, 8'h00, 5'd21, 5'd0, 8'h00, 5'd1);
        send_key(8'h00);
        drive_beat(CMD_LEN, 8'h00, 5'd21, 5'd0, 8'h00, 5'd0);
        // spare selector with every payload bit set
        drive_beat(CMD_SPARE, 8'hff, 5'd31, 5'd31, 8'hff, 5'd31);
        drive_beat(CMD_LEN, 8'h00, 5'd31, 5'd0, 8'h00, 5'd0);

        run_random(PHASE_BEATS);

        // swap the idling sides
        tx_idle_pct = 73;
        rx_idle_pct = 9;
        run_random(PHASE_BEATS);

        // no idling; open with a long receiver hold-off so the block backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        run_random(PHASE_BEATS);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d key, %0d load, %0d length and %0d spare-selector beats",
                 sb.n_key, sb.n_load, sb.n_len, sb.n_spare);
        $display("%0d keyword hits, with and without stalls and one long output hold-off",
                 sb.n_hits);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("sliding_window_keyword_matcher: match");
        end
        else
        begin
            $display("sliding_window_keyword_matcher: mismatch");
        end
        $finish;
    end

endmodule
